// ===== hw/rtl/bwt_block_transform_core_macros.svh =====
// Assertion macros used by the block's top-level RTL file.
`ifndef BWT_BLOCK_TRANSFORM_CORE_MACROS_SVH
`define BWT_BLOCK_TRANSFORM_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BWT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BWT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/bwt_pkg.sv =====
package bwt_pkg;

    localparam int BLOCK_SIZE_DEF = 64;
    localparam int SYM_W          = 8;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef struct packed {
        logic load;
        logic start;
        logic next_j;
        logic next_j_less;
        logic step_k;
        logic rank_rd;
        logic wr_pos;
        logic out_init;
        logic pos_rd;
        logic pre_latch;
        logic sym_rd;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic j_done;
        logic j_eq_i;
        logic decided;
        logic less;
        logic i_last;
        logic dir;
        logic r_last;
        logic out_busy;
    } sts_t;

endpackage

// ===== hw/rtl/bwt_dp.sv =====
module bwt_dp #(
    parameter int BLOCK_SIZE = bwt_pkg::BLOCK_SIZE_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic                     cfg_data,
    input  logic [bwt_pkg::SYM_W-1:0] symbol,
    input  logic                     out_stall,
    input  bwt_pkg::cmd_t            cmd,
    output bwt_pkg::sts_t            sts,
    output logic                     out_valid,
    output logic [bwt_pkg::SYM_W-1:0] out_symbol,
    output logic                     out_last
);
    localparam int AW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int CW = $clog2(BLOCK_SIZE + 1);
    localparam int SW = bwt_pkg::SYM_W;

    logic [SW-1:0] sym_mem [BLOCK_SIZE];
    logic [AW-1:0] pos_mem [BLOCK_SIZE];

    logic          dir_cfg_reg;
    logic          dir_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] r_reg;
    logic [AW-1:0] cur_reg;
    logic          zero_reg;
    logic          a_in_reg;
    logic          b_in_reg;
    logic [SW-1:0] sym_a_reg;
    logic [SW-1:0] sym_b_reg;
    logic [AW-1:0] pos_q_reg;
    logic          out_valid_reg;
    logic [SW-1:0] out_symbol_reg;
    logic          out_last_reg;

    logic [CW:0]   sum_a;
    logic [CW:0]   sum_b;
    logic [AW-1:0] sym_addr_a;
    logic [AW-1:0] pos_addr;
    logic [SW:0]   val_a;
    logic [SW:0]   val_b;

    assign sum_a = {1'b0, j_reg} + {1'b0, k_reg};
    assign sum_b = {1'b0, i_reg} + {1'b0, k_reg};
    assign sym_addr_a = cmd.sym_rd
        ? ((dir_reg == bwt_pkg::DIR_DECODE) ? pos_q_reg : (pos_q_reg - AW'(1)))
        : sum_a[AW-1:0];
    assign pos_addr = (dir_reg == bwt_pkg::DIR_DECODE) ? cur_reg : r_reg[AW-1:0];

    always_comb
    begin
        if (dir_reg == bwt_pkg::DIR_DECODE)
        begin
            val_a = {1'b0, sym_a_reg};
            val_b = {1'b0, sym_b_reg};
        end
        else
        begin
            val_a = a_in_reg ? ({1'b0, sym_a_reg} + (SW+1)'(1)) : '0;
            val_b = b_in_reg ? ({1'b0, sym_b_reg} + (SW+1)'(1)) : '0;
        end
    end

    always_comb
    begin
        sts.full     = (fill_reg == CW'(BLOCK_SIZE - 1));
        sts.j_done   = (j_reg == n_reg);
        sts.j_eq_i   = (j_reg == i_reg);
        sts.decided  = (val_a != val_b) || (dir_reg == bwt_pkg::DIR_DECODE);
        sts.less     = (val_a < val_b) || ((val_a == val_b) && (j_reg < i_reg));
        sts.i_last   = (i_reg == n_reg - CW'(1));
        sts.dir      = dir_reg;
        sts.r_last   = (r_reg == n_reg - CW'(1));
        sts.out_busy = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sym_mem[fill_reg[AW-1:0]] <= symbol;
        end
        if (cmd.rank_rd || cmd.sym_rd)
        begin
            sym_a_reg <= sym_mem[sym_addr_a];
        end
        if (cmd.rank_rd)
        begin
            sym_b_reg <= sym_mem[sum_b[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_pos)
        begin
            pos_mem[cnt_reg[AW-1:0]] <= i_reg[AW-1:0];
        end
        if (cmd.pos_rd)
        begin
            pos_q_reg <= pos_mem[pos_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rank_rd)
        begin
            a_in_reg <= (sum_a < {1'b0, n_reg});
            b_in_reg <= (sum_b < {1'b0, n_reg});
        end
        if (cmd.sym_rd)
        begin
            zero_reg <= (dir_reg == bwt_pkg::DIR_ENCODE) && (pos_q_reg == '0);
        end
        if (cmd.emit)
        begin
            out_symbol_reg <= zero_reg ? '0 : sym_a_reg;
            out_last_reg   <= sts.r_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_cfg_reg   <= bwt_pkg::DIR_ENCODE;
            dir_reg       <= bwt_pkg::DIR_ENCODE;
            fill_reg      <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            r_reg         <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                dir_cfg_reg <= cfg_data;
            end
            if (cmd.load && !cmd.start)
            begin
                fill_reg <= fill_reg + CW'(1);
            end
            if (cmd.start)
            begin
                fill_reg <= '0;
                n_reg    <= fill_reg + CW'(1);
                dir_reg  <= dir_cfg_reg;
                i_reg    <= '0;
                j_reg    <= '0;
                k_reg    <= '0;
                cnt_reg  <= '0;
            end
            if (cmd.next_j || cmd.next_j_less)
            begin
                j_reg <= j_reg + CW'(1);
                k_reg <= '0;
            end
            if (cmd.next_j_less)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.step_k)
            begin
                k_reg <= k_reg + CW'(1);
            end
            if (cmd.wr_pos)
            begin
                i_reg   <= i_reg + CW'(1);
                j_reg   <= '0;
                k_reg   <= '0;
                cnt_reg <= '0;
            end
            if (cmd.out_init)
            begin
                r_reg   <= '0;
                cur_reg <= '0;
            end
            if (cmd.pre_latch || cmd.sym_rd)
            begin
                cur_reg <= pos_q_reg;
            end
            if (cmd.emit)
            begin
                r_reg         <= r_reg + CW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_symbol_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== hw/rtl/bwt_ctrl.sv =====
module bwt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          last,
    input  bwt_pkg::sts_t sts,
    output logic          in_stall,
    output bwt_pkg::cmd_t cmd
);
    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_RANK_RD  = 4'd1;
    localparam logic [3:0] S_RANK_CMP = 4'd2;
    localparam logic [3:0] S_WR_POS   = 4'd3;
    localparam logic [3:0] S_OUT_INIT = 4'd4;
    localparam logic [3:0] S_PRE_RD   = 4'd5;
    localparam logic [3:0] S_PRE_LAT  = 4'd6;
    localparam logic [3:0] S_OUT_RD   = 4'd7;
    localparam logic [3:0] S_OUT_SYM  = 4'd8;
    localparam logic [3:0] S_OUT_EMIT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_LOAD);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (last || sts.full)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_RANK_RD;
                    end
                end
            end
            S_RANK_RD:
            begin
                if (sts.j_done)
                begin
                    state_next = S_WR_POS;
                end
                else if (sts.j_eq_i)
                begin
                    cmd.next_j = 1'b1;
                end
                else
                begin
                    cmd.rank_rd = 1'b1;
                    state_next  = S_RANK_CMP;
                end
            end
            S_RANK_CMP:
            begin
                state_next = S_RANK_RD;
                if (!sts.decided)
                begin
                    cmd.step_k = 1'b1;
                end
                else if (sts.less)
                begin
                    cmd.next_j_less = 1'b1;
                end
                else
                begin
                    cmd.next_j = 1'b1;
                end
            end
            S_WR_POS:
            begin
                cmd.wr_pos = 1'b1;
                state_next = sts.i_last ? S_OUT_INIT : S_RANK_RD;
            end
            S_OUT_INIT:
            begin
                cmd.out_init = 1'b1;
                state_next   = (sts.dir == bwt_pkg::DIR_DECODE) ? S_PRE_RD : S_OUT_RD;
            end
            S_PRE_RD:
            begin
                cmd.pos_rd = 1'b1;
                state_next = S_PRE_LAT;
            end
            S_PRE_LAT:
            begin
                cmd.pre_latch = 1'b1;
                state_next    = S_OUT_RD;
            end
            S_OUT_RD:
            begin
                cmd.pos_rd = 1'b1;
                state_next = S_OUT_SYM;
            end
            S_OUT_SYM:
            begin
                cmd.sym_rd = 1'b1;
                state_next = S_OUT_EMIT;
            end
            S_OUT_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.r_last ? S_LOAD : S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/bwt_block_transform_core.sv =====
// Block Burrows-Wheeler transform, forward and inverse.
// Input items (symbol, last) are taken on the in channel while the block loads.
// A block ends on an item with last set, or after BLOCK_SIZE items. in_stall
// then stays high until every result of the block has been handed to the
// output register. Exactly one result item leaves per input item of the
// block, with out_last set on the final one.
// cfg_data is taken into the direction register on any cycle with cfg_write
// high (0 encode, 1 decode); it is sampled when a block ends.
// For a block of n symbols the ranking pass compares every pair of positions,
// reading both symbols at once from the two-port symbol memory. Decode
// compares single symbols; encode steps through the common prefix of the
// compared suffixes. Emission then runs S_OUT_INIT, in decode followed by
// S_PRE_RD and S_PRE_LAT, then per item a position read, a symbol read and
// an emit; the emit waits while the output is stalled.
// Each item is held in the output register until taken; a stalled receiver
// freezes the emission sequence without loss. Reset clears the fill count,
// the direction register and the output valid, and the block waits for input.
module bwt_block_transform_core #(
    parameter int BLOCK_SIZE = bwt_pkg::BLOCK_SIZE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic                      cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [bwt_pkg::SYM_W-1:0] symbol,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [bwt_pkg::SYM_W-1:0] out_symbol,
    output logic                      out_last
);
    `include "bwt_block_transform_core_macros.svh"

    bwt_pkg::cmd_t cmd;
    bwt_pkg::sts_t sts;

    bwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    bwt_dp #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .symbol     (symbol),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_symbol (out_symbol),
        .out_last   (out_last)
    );

    `BWT_ASSERT_NEXT(a_busy_after_end, clk, rst_n, in_valid && !in_stall && last, in_stall)
    `BWT_ASSERT_NEXT(a_quiet_after_last, clk, rst_n,
        out_valid && !out_stall && out_last, !out_valid)
    `BWT_ASSERT_SAME(a_emit_when_free, clk, rst_n, cmd.emit, !sts.out_busy)

endmodule

// ===== tb/sv/bwt_block_transform_core_tb.sv =====
`timescale 1ns / 100ps

module bwt_block_transform_core_tb;

    localparam int NSYM  = 64;
    localparam int SYM_W = bwt_pkg::SYM_W;

    typedef struct {
        logic [SYM_W-1:0] sym;
        logic             lst;
    } bwt_out_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    logic             cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             out_valid;
    logic             out_stall;
    logic [SYM_W-1:0] out_symbol;
    logic             out_last;

    bwt_block_transform_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .symbol(symbol), .last(last),
        .out_valid(out_valid), .out_stall(out_stall), .out_symbol(out_symbol),
        .out_last(out_last)
    );

    logic [SYM_W-1:0] blk_sym [NSYM];
    int               rk_hi [NSYM];
    int               rk_lo [NSYM];
    int               order [NSYM];
    int               rk_new [NSYM];
    int               blk_fill;
    logic             dir_reg;
    bwt_out_t         transformed_q [$];
    int               errors;
    int               checked;
    int               enc_blocks;
    int               dec_blocks;
    int               send_idle;
    int               recv_idle;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("timeout at %0t", $time);
        $display("bwt_block_transform_core_tb: errors");
        $finish;
    end

    function automatic void queue_result(bwt_out_t res);
        transformed_q.insert(transformed_q.size(), res);
    endfunction

    function automatic bit rank_less(int a, int b);
        if (rk_hi[a] != rk_hi[b])
        begin
            return rk_hi[a] < rk_hi[b];
        end
        return rk_lo[a] < rk_lo[b];
    endfunction

    function automatic void sort_suffixes(int n);
        int v;
        int j;
        for (int i = 1; i < n; i++)
        begin
            v = order[i];
            j = i;
            while (j > 0 && rank_less(v, order[j - 1]))
            begin
                order[j] = order[j - 1];
                j--;
            end
            order[j] = v;
        end
    endfunction

    function automatic void forward_block(int n);
        int r;
        int p;
        bwt_out_t res;
        for (int q = 0; q < n; q++)
        begin
            order[q] = q;
            rk_hi[q] = blk_sym[q] + 1;
            rk_lo[q] = (q + 1 < n) ? blk_sym[q + 1] + 1 : 0;
        end
        sort_suffixes(n);
        for (int k = 4; k < 2 * n; k *= 2)
        begin
            r = 0;
            for (int i = 0; i < n; i++)
            begin
                if (i > 0 && (rk_hi[order[i]] != rk_hi[order[i - 1]] ||
                              rk_lo[order[i]] != rk_lo[order[i - 1]]))
                begin
                    r++;
                end
                rk_new[order[i]] = r;
            end
            for (int q = 0; q < n; q++)
            begin
                rk_hi[q] = rk_new[q] + 1;
                rk_lo[q] = (q + k / 2 < n) ? rk_new[q + k / 2] + 1 : 0;
            end
            sort_suffixes(n);
        end
        for (int i = 0; i < n; i++)
        begin
            p = order[i];
            res.sym = (p == 0) ? '0 : blk_sym[p - 1];
            res.lst = (i + 1 == n);
            queue_result(res);
        end
    endfunction

    function automatic void inverse_block(int n);
        int j;
        int cur;
        int idx;
        bwt_out_t res;
        for (int i = 0; i < n; i++)
        begin
            j = i;
            while (j > 0 && blk_sym[i] < blk_sym[order[j - 1]])
            begin
                order[j] = order[j - 1];
                j--;
            end
            order[j] = i;
        end
        cur = order[0];
        for (int i = 0; i < n; i++)
        begin
            idx = cur & (NSYM - 1);
            res.sym = blk_sym[order[idx]];
            res.lst = (i + 1 == n);
            queue_result(res);
            cur = order[idx];
        end
    endfunction

    function automatic void predict_item(logic [SYM_W-1:0] s, logic l);
        int n;
        blk_sym[blk_fill] = s;
        blk_fill++;
        if (l || blk_fill >= NSYM)
        begin
            n = blk_fill;
            blk_fill = 0;
            if (dir_reg == bwt_pkg::DIR_DECODE)
            begin
                inverse_block(n);
                dec_blocks++;
            end
            else
            begin
                forward_block(n);
                enc_blocks++;
            end
        end
    endfunction

    task automatic send_item(logic [SYM_W-1:0] s, logic l);
        in_valid <= 1'b1;
        symbol   <= s;
        last     <= l;
        do
            @(posedge clk);
        while (in_stall);
        predict_item(s, l);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_direction(logic d);
        end_burst();
        while (transformed_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= d;
        @(posedge clk);
        cfg_write <= 1'b0;
        dir_reg = d;
    endtask

    // Results are checked and the receiver stall is chosen on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (transformed_q.size() == 0)
                begin
                    $display("%0t: unexpected item sym=%0d last=%0d",
                             $time, out_symbol, out_last);
                    errors++;
                end
                else
                begin
                    if (out_symbol !== transformed_q[0].sym ||
                        out_last !== transformed_q[0].lst)
                    begin
                        $display("%0t: expected sym=%0d last=%0d, actual sym=%0d last=%0d",
                                 $time, transformed_q[0].sym, transformed_q[0].lst,
                                 out_symbol, out_last);
                        errors++;
                    end
                    void'(transformed_q.pop_front());
                    checked++;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic send_block(int n, bit terminated, bit flag_end);
        for (int i = 0; i < n; i++)
        begin
            if (terminated)
            begin
                send_item((i == n - 1) ? 8'd0 : SYM_W'($urandom_range(1, 255)),
                          flag_end && (i == n - 1));
            end
            else
            begin
                send_item(SYM_W'($urandom_range(0, 255)), flag_end && (i == n - 1));
            end
        end
    endtask

    task automatic test_directed_encode();
        set_direction(bwt_pkg::DIR_ENCODE);
        send_item(8'd0, 1'b1);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b1);
        for (int i = 0; i < 6; i++)
            send_item(8'd7, i == 5);
        send_item(8'd255, 1'b0);
        send_item(8'd1, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b1);
    endtask

    task automatic test_directed_decode();
        set_direction(bwt_pkg::DIR_DECODE);
        send_item(8'd255, 1'b1);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b1);
        send_item(8'd3, 1'b0);
        send_item(8'd3, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd3, 1'b1);
    endtask

    // A block without a last flag closes at the size bound; the next item
    // starts a new block.
    task automatic test_block_size_bound();
        set_direction(bwt_pkg::DIR_ENCODE);
        send_block(NSYM, 1'b0, 1'b0);
        send_block(3, 1'b1, 1'b1);
    endtask

    task automatic test_random_mix(int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(3) == 0)
            begin
                set_direction(logic'($urandom_range(1)));
            end
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            send_block(n, (dir_reg == bwt_pkg::DIR_ENCODE) && ($urandom_range(3) != 0),
                       1'b1);
            sent += n;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = 1'b0;
        in_valid  = 1'b0;
        symbol    = '0;
        last      = 1'b0;
        out_stall = 1'b0;
        errors    = 0;
        checked   = 0;
        enc_blocks = 0;
        dec_blocks = 0;
        blk_fill  = 0;
        dir_reg   = bwt_pkg::DIR_ENCODE;
        send_idle = 0;
        recv_idle = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 9;
        recv_idle = 73;
        test_directed_encode();
        test_directed_decode();
        test_random_mix(6);
        send_idle = 73;
        recv_idle = 9;
        test_random_mix(6);
        send_idle = 0;
        recv_idle = 0;
        test_block_size_bound();
        test_random_mix(6);

        end_burst();
        while (transformed_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d encoded and %0d decoded blocks, %0d result items checked",
                 enc_blocks, dec_blocks, checked);
        if (errors == 0)
        begin
            $display("bwt_block_transform_core_tb: clean");
        end
        else
        begin
            $display("bwt_block_transform_core_tb: errors");
        end
        $finish;
    end

endmodule
